### sv/b64d_pkg.sv
// Shared types, character constants and the character classifier.
// Used by the front, queue and back modules of base64_stream_decoder.
package b64d_pkg;

  localparam int unsigned B64D_QDEPTH = 2;
  localparam int unsigned B64D_SHOWN_W = 16;

  localparam logic [7:0] CHAR_SPACE   = 8'd32;
  localparam logic [7:0] CHAR_TAB     = 8'd9;
  localparam logic [7:0] CHAR_CR      = 8'd13;
  localparam logic [7:0] CHAR_UPPER_A = 8'd65;
  localparam logic [7:0] CHAR_UPPER_Z = 8'd90;
  localparam logic [7:0] CHAR_LOWER_A = 8'd97;
  localparam logic [7:0] CHAR_LOWER_Z = 8'd122;
  localparam logic [7:0] CHAR_ZERO    = 8'd48;
  localparam logic [7:0] CHAR_NINE    = 8'd57;
  localparam logic [7:0] CHAR_PLUS    = 8'd43;
  localparam logic [7:0] CHAR_SLASH   = 8'd47;

  localparam logic [7:0] LOWER_BASE = 8'd26;
  localparam logic [7:0] DIGIT_BASE = 8'd52;
  localparam logic [5:0] CODE_PLUS  = 6'd62;
  localparam logic [5:0] CODE_SLASH = 6'd63;

  typedef enum logic [1:0] {
    KIND_DATA,
    KIND_SPACE,
    KIND_NONE
  } b64d_kind_e;

  typedef struct packed {
    b64d_kind_e kind;
    logic [5:0] code;
    logic       last;
  } b64d_item_t;

  function automatic b64d_item_t b64d_classify(logic [7:0] c, logic last);
    b64d_item_t it;
    logic [7:0] d;
    it.last = last;
    it.code = '0;
    it.kind = KIND_NONE;
    d = '0;
    priority if (c == CHAR_SPACE || (c >= CHAR_TAB && c <= CHAR_CR)) begin
      it.kind = KIND_SPACE;
    end else if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) begin
      d = c - CHAR_UPPER_A;
      it.kind = KIND_DATA;
      it.code = d[5:0];
    end else if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z) begin
      d = c - CHAR_LOWER_A + LOWER_BASE;
      it.kind = KIND_DATA;
      it.code = d[5:0];
    end else if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
      d = c - CHAR_ZERO + DIGIT_BASE;
      it.kind = KIND_DATA;
      it.code = d[5:0];
    end else if (c == CHAR_PLUS) begin
      it.kind = KIND_DATA;
      it.code = CODE_PLUS;
    end else if (c == CHAR_SLASH) begin
      it.kind = KIND_DATA;
      it.code = CODE_SLASH;
    end else begin
      it.kind = KIND_NONE;
    end
    return it;
  endfunction

endpackage

### sv/b64d_front.sv
// Input stage: accepts characters, classifies them and holds one item.
// Depends on b64d_pkg; feeds b64d_queue.
module b64d_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [7:0]           in_char_i,
  input  logic                 msg_last_i,
  output logic                 push_o,
  output b64d_pkg::b64d_item_t item_o,
  input  logic                 q_full_i
);
  import b64d_pkg::*;

  logic       valid_q, valid_d;
  b64d_item_t item_q;
  logic       accept;

  assign push_o     = valid_q && !q_full_i;
  assign in_stall_o = valid_q && q_full_i;
  assign accept     = in_valid_i && !in_stall_o;
  assign valid_d    = accept || (valid_q && !push_o);
  assign item_o     = item_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= b64d_classify(in_char_i, msg_last_i);
    end
  end

endmodule

### sv/b64d_queue.sv
// Short FIFO of classified items between the front and back stages.
// Depends on b64d_pkg for the item type and depth.
module b64d_queue (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  b64d_pkg::b64d_item_t item_i,
  output logic                 full_o,
  input  logic                 pop_i,
  output b64d_pkg::b64d_item_t item_o,
  output logic                 empty_o
);
  import b64d_pkg::*;

  localparam int unsigned PTR_W = $clog2(B64D_QDEPTH);
  localparam int unsigned CNT_W = $clog2(B64D_QDEPTH + 1);

  b64d_item_t       mem_q [B64D_QDEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;

  assign full_o  = (count_q == CNT_W'(B64D_QDEPTH));
  assign empty_o = (count_q == '0);
  assign item_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? wr_ptr_q + PTR_W'(1) : wr_ptr_q;
    rd_ptr_d = pop_i ? rd_ptr_q + PTR_W'(1) : rd_ptr_q;
    count_d  = count_q;
    unique case ({push_i, pop_i})
      2'b10:   count_d = count_q + CNT_W'(1);
      2'b01:   count_d = count_q - CNT_W'(1);
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o)
    else $error("queue popped while empty");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(B64D_QDEPTH))
    else $error("queue count beyond depth");

endmodule

### sv/b64d_back.sv
// Decode stage: packs 6-bit codes into bytes, counts bytes, registers results.
// Depends on b64d_pkg; drains b64d_queue.
module b64d_back #(
  parameter int unsigned COUNT_BITS = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 empty_i,
  input  b64d_pkg::b64d_item_t item_i,
  output logic                 pop_o,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [7:0]           out_byte_o,
  output logic                 byte_valid_o,
  output logic                 end_of_message_o,
  output logic                 stopped_invalid_o,
  output logic [15:0]          decoded_count_o
);
  import b64d_pkg::*;

  logic [1:0]            phase_q, phase_d;
  logic [7:0]            part_q, part_d;
  logic                  skip_q, skip_d;
  logic [COUNT_BITS-1:0] cnt_q, cnt_d, cnt_step;
  logic [B64D_SHOWN_W-1:0] cnt_shown;

  logic       have_byte;
  logic [7:0] byte_val;
  logic       produce;
  logic       out_free;

  logic                    out_valid_q;
  logic [7:0]              out_byte_q;
  logic                    byte_valid_q;
  logic                    eom_q;
  logic                    stop_q;
  logic [B64D_SHOWN_W-1:0] count_q;

  assign out_free = !out_valid_q || !out_stall_i;
  assign pop_o    = !empty_i && out_free;

  always_comb begin
    phase_d   = phase_q;
    part_d    = part_q;
    skip_d    = skip_q;
    have_byte = 1'b0;
    byte_val  = '0;
    if (!skip_q) begin
      unique case (item_i.kind)
        KIND_NONE:  skip_d = 1'b1;
        KIND_DATA: begin
          unique case (phase_q)
            2'd0: begin
              part_d  = {item_i.code, 2'b00};
              phase_d = 2'd1;
            end
            2'd1: begin
              byte_val  = part_q | {6'b0, item_i.code[5:4]};
              part_d    = {item_i.code[3:0] & 4'h0f, 4'b0};
              have_byte = 1'b1;
              phase_d   = 2'd2;
            end
            2'd2: begin
              byte_val  = part_q | {4'b0, item_i.code[5:2]};
              part_d    = {item_i.code[1:0] & 2'h3, 6'b0};
              have_byte = 1'b1;
              phase_d   = 2'd3;
            end
            default: begin
              byte_val  = part_q | {2'b0, item_i.code};
              part_d    = '0;
              have_byte = 1'b1;
              phase_d   = 2'd0;
            end
          endcase
        end
        default: skip_d = skip_q;
      endcase
    end
    cnt_step = (have_byte && cnt_q != '1) ? cnt_q + COUNT_BITS'(1) : cnt_q;
    produce  = have_byte || item_i.last;
    cnt_d    = cnt_step;
    if (item_i.last) begin
      phase_d = '0;
      part_d  = '0;
      cnt_d   = '0;
    end
  end

  generate
    if (COUNT_BITS > B64D_SHOWN_W) begin : g_sat
      assign cnt_shown = (|cnt_step[COUNT_BITS-1:B64D_SHOWN_W]) ? '1
                                                              : cnt_step[B64D_SHOWN_W-1:0];
    end else begin : g_ext
      assign cnt_shown = B64D_SHOWN_W'(cnt_step);
    end
  endgenerate

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= '0;
      part_q      <= '0;
      skip_q      <= 1'b0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (pop_o) begin
        phase_q <= phase_d;
        part_q  <= part_d;
        skip_q  <= item_i.last ? 1'b0 : skip_d;
        cnt_q   <= cnt_d;
      end
      if (out_free) begin
        out_valid_q <= pop_o && produce;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o && produce) begin
      out_byte_q   <= byte_val;
      byte_valid_q <= have_byte;
      eom_q        <= item_i.last;
      stop_q       <= item_i.last && skip_d;
      count_q      <= cnt_shown;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign out_byte_o        = out_byte_q;
  assign byte_valid_o      = byte_valid_q;
  assign end_of_message_o  = eom_q;
  assign stopped_invalid_o = stop_q;
  assign decoded_count_o   = count_q;

  a_stop_on_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && stop_q |-> eom_q)
    else $error("invalid stop flagged on a non-closing transaction");

  a_clear_at_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o && item_i.last |=> phase_q == '0 && !skip_q && cnt_q == '0)
    else $error("state not cleared at message end");

  a_byte_counted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && byte_valid_q |-> count_q != '0)
    else $error("byte transaction with zero count");

endmodule

### sv/base64_stream_decoder.sv
// Top level of the Base64 stream decoder: front, queue and back stages.
// Depends on b64d_pkg, b64d_front, b64d_queue and b64d_back.
//
//   channel | direction | handshake          | payload
//   --------+-----------+--------------------+-----------------------------------------
//   in      | input     | in_valid_i/stall_o | in_char_i, msg_last_i
//   out     | output    | out_valid_o/stall_i| out_byte_o, byte_valid_o, end_of_message_o,
//           |           |                    | stopped_invalid_o, decoded_count_o
//
// One character per cycle sustained while the output is not stalled; a character
// passes through the front register, a queue entry, then the output register of the back stage.
// Reset clears the decode state, the queue and both stage valids at once.
// A stalled output backs up into the two-entry queue, then the front register,
// and only then raises in_stall_o.
module base64_stream_decoder #(
  parameter int unsigned COUNT_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  in_char_i,
  input  logic        msg_last_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  out_byte_o,
  output logic        byte_valid_o,
  output logic        end_of_message_o,
  output logic        stopped_invalid_o,
  output logic [15:0] decoded_count_o
);
  import b64d_pkg::*;

  logic       push;
  logic       pop;
  logic       q_full;
  logic       q_empty;
  b64d_item_t front_item;
  b64d_item_t back_item;

  b64d_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_char_i  (in_char_i),
    .msg_last_i (msg_last_i),
    .push_o     (push),
    .item_o     (front_item),
    .q_full_i   (q_full)
  );

  b64d_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (front_item),
    .full_o  (q_full),
    .pop_i   (pop),
    .item_o  (back_item),
    .empty_o (q_empty)
  );

  b64d_back #(
    .COUNT_BITS (COUNT_BITS)
  ) u_back (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .empty_i           (q_empty),
    .item_i            (back_item),
    .pop_o             (pop),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .out_byte_o        (out_byte_o),
    .byte_valid_o      (byte_valid_o),
    .end_of_message_o  (end_of_message_o),
    .stopped_invalid_o (stopped_invalid_o),
    .decoded_count_o   (decoded_count_o)
  );

endmodule
